[sv/spq_pkg.sv]
// Package for the sorted priority queue: shared types, codes and defaults.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_unit; no dependencies.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 8;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_STEP,
        ST_ENQ_CMP,
        ST_DEQ_STEP,
        ST_DEQ_OUT
    } state_t;

    typedef struct packed {
        logic [PRIO_W-1:0]         prio;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic enq_rd;
        logic enq_shift;
        logic enq_place;
        logic enq_full;
        logic deq_rd;
        logic deq_pop;
        logic deq_empty;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic k_zero;
        logic lower;
    } stat_t;

endpackage

[sv/spq_ctrl.sv]
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; drives spq_datapath through cmd_t, reads stat_t.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  action,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = action ? ST_DEQ_STEP : ST_ENQ_STEP;
                end
            end
            ST_ENQ_STEP:
            begin
                priority if (stat.full)
                begin
                    cmd.enq_full = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.k_zero)
                begin
                    cmd.enq_place = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.enq_rd = 1'b1;
                    state_next = ST_ENQ_CMP;
                end
            end
            ST_ENQ_CMP:
            begin
                if (stat.lower)
                begin
                    cmd.enq_shift = 1'b1;
                    state_next    = ST_ENQ_STEP;
                end
                else
                begin
                    cmd.enq_place = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DEQ_STEP:
            begin
                if (stat.empty)
                begin
                    cmd.deq_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.deq_rd = 1'b1;
                    state_next = ST_DEQ_OUT;
                end
            end
            ST_DEQ_OUT:
            begin
                cmd.deq_pop = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/spq_datapath.sv]
// Datapath of the sorted priority queue: circular entry memory, pointers, result registers.
// Depends on spq_pkg; commanded by spq_ctrl through cmd_t, reports stat_t.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [PRIO_W-1:0]         prio,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [PRIO_W-1:0]         out_prio,
    output logic [OCC_W-1:0]          occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    entry_t mem [DEPTH];

    entry_t                    rdata_reg;
    entry_t                    new_reg;
    logic [AW-1:0]             head_reg;
    logic [AW-1:0]             head_next;
    logic [AW-1:0]             tail_reg;
    logic [AW-1:0]             tail_next;
    logic [AW-1:0]             hole_reg;
    logic [AW-1:0]             hole_prev;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             k_reg;
    logic                      done_reg;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [PRIO_W-1:0]         out_prio_reg;
    logic [OCC_W-1:0]          occupancy_reg;
    logic [AW-1:0]             rd_addr;
    logic                      rd_en;

    assign head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign hole_prev = (hole_reg == '0) ? LAST : hole_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq_place)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign rd_en   = cmd.enq_rd | cmd.deq_rd;
    assign rd_addr = cmd.deq_rd ? head_reg : hole_prev;

    assign stat.full   = (count_reg == CW'(DEPTH));
    assign stat.empty  = (count_reg == '0);
    assign stat.k_zero = (k_reg == '0);
    assign stat.lower  = (rdata_reg.prio < new_reg.prio);

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.enq_shift)
        begin
            mem[hole_reg] <= rdata_reg;
        end
        else if (cmd.enq_place)
        begin
            mem[hole_reg] <= new_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            new_reg.value <= value;
            new_reg.prio  <= prio;
        end
        if (cmd.enq_place | cmd.enq_full | cmd.deq_empty | cmd.deq_pop)
        begin
            out_value_reg <= cmd.deq_pop ? rdata_reg.value : '0;
            out_prio_reg  <= cmd.deq_pop ? rdata_reg.prio : '0;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            hole_reg   <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.enq_place | cmd.enq_full | cmd.deq_empty | cmd.deq_pop;
            if (cmd.load_in)
            begin
                hole_reg <= tail_reg;
                k_reg    <= count_reg;
            end
            else if (cmd.enq_shift)
            begin
                hole_reg <= hole_prev;
                k_reg    <= k_reg - 1'b1;
            end
            if (cmd.enq_place)
            begin
                tail_reg <= tail_next;
            end
            if (cmd.deq_pop)
            begin
                head_reg <= head_next;
            end
            priority if (cmd.enq_full)
            begin
                status_reg <= STATUS_FULL;
            end
            else if (cmd.deq_empty)
            begin
                status_reg <= STATUS_EMPTY;
            end
            else if (cmd.enq_place | cmd.deq_pop)
            begin
                status_reg <= STATUS_OK;
            end
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign out_prio  = out_prio_reg;
    assign occupancy = occupancy_reg;

endmodule

[sv/sorted_priority_queue_unit.sv]
// Sorted priority queue, DEPTH entries, top level.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Command channel: an item (action, value, prio) is taken at a rising edge where
// start is high and busy is low. action 0 enqueues value at priority prio; action 1
// dequeues the highest priority entry, earliest arrival first among equal priorities.
// Result channel: done is high for exactly one cycle with status, out_value, out_prio
// and occupancy; the receiver must take it then, there is no stall.
// Entries live in a circular single-port-read memory. A dequeue reads the head, then
// pops it and registers the result. An enqueue walks back from the tail, one read
// and one move per held entry of lower priority, until it passes all held entries or
// stops at an entry of greater or equal priority. A full enqueue or an empty dequeue
// finishes without a memory access. busy drops in the cycle done rises, so the next
// start may coincide with the result strobe.
// Reset empties the queue at once; the memory holds no reset value and needs no sweep.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [PRIO_W-1:0]         prio,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [PRIO_W-1:0]         out_prio,
    output logic [OCC_W-1:0]          occupancy
);

    cmd_t  cmd;
    stat_t stat;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .prio      (prio),
        .done      (done),
        .status    (status),
        .out_value (out_value),
        .out_prio  (out_prio),
        .occupancy (occupancy)
    );

endmodule
